>>> src/pid_autotune_heater_control_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the autotuned heater controller
// Concurrent checks, clocked on the rising edge, off while reset is held.
// ----------------------------------------------------------------------------
`ifndef PID_AUTOTUNE_HEATER_CONTROL_ASSERT_SVH
`define PID_AUTOTUNE_HEATER_CONTROL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PAHC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("pahc check failed");
`define PAHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("pahc implication failed");
`else
`define PAHC_ASSERT(lbl, clk, rst_n, prop)
`define PAHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/pahc_pkg.sv
// ----------------------------------------------------------------------------
// Autotuned heater controller package
// Shared widths, register indexes, datapath opcodes and command types.
// ----------------------------------------------------------------------------
package pahc_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int TEMP_W      = 12;
	localparam int GAIN_W      = 24;
	localparam int STEP_W      = 16;
	localparam int TICK_W      = 24;
	localparam int LIM_W       = 16;
	localparam int DUTY_W      = 8;
	localparam int TIME_W      = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int DIGIT_W     = 8;
	localparam int IDX_W       = 3;
	localparam int ITERM_CAP_W = 61;

	localparam logic [ITERM_CAP_W-1:0] ITERM_CAP = {1'b1, {(ITERM_CAP_W-1){1'b0}}};

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_TARGET_TEMP    = 3'd0;
	localparam cfg_idx_t REG_GAIN_START     = 3'd1;
	localparam cfg_idx_t REG_GAIN_STEP      = 3'd2;
	localparam cfg_idx_t REG_TICK_PERIOD    = 3'd3;
	localparam cfg_idx_t REG_INTEGRAL_LIMIT = 3'd4;
	localparam cfg_idx_t REG_DUTY_LIMIT     = 3'd5;

	localparam logic [TEMP_W-1:0] TARGET_RST     = 12'd370;
	localparam logic [GAIN_W-1:0] GAIN_START_RST = 24'd6554;
	localparam logic [STEP_W-1:0] GAIN_STEP_RST  = 16'd328;
	localparam logic [TICK_W-1:0] TICK_RST       = 24'd6554;
	localparam logic [LIM_W-1:0]  LIMIT_RST      = 16'd200;
	localparam logic [DUTY_W-1:0] DUTY_LIM_RST   = 8'd200;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ERR,
		OP_TUNE,
		OP_TUNE_DUTY,
		OP_KP,
		OP_INTEG,
		OP_DIV_STEP,
		OP_IMUL_INIT,
		OP_IMUL_STEP,
		OP_ICAP,
		OP_SUM,
		OP_RUN_DUTY
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [IDX_W-1:0] idx;
		logic             capture;
		logic             out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic tuned;
	} dp_stat_t;

	// quotient width of Ki = (Kp << (F+1)) / Tu
	function automatic int ki_width(input int f);
		return GAIN_W + f + 1;
	endfunction

	// digits of the integral magnitude fed to the I-term multiplier
	function automatic int digit_count(input int f);
		return (LIM_W + f + DIGIT_W - 1) / DIGIT_W;
	endfunction

endpackage

>>> src/pahc_ctrl.sv
// ----------------------------------------------------------------------------
// Autotuned heater controller sequencer
// Walks one request through the datapath steps and owns the handshakes.
// ----------------------------------------------------------------------------
module pahc_ctrl #(
	parameter int FRAC_BITS = pahc_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  pahc_pkg::dp_stat_t stat,
	output pahc_pkg::dp_cmd_t  cmd
);
`include "pid_autotune_heater_control_assert.svh"

	localparam int DIV_STEPS = pahc_pkg::ki_width(FRAC_BITS);
	localparam int MUL_STEPS = pahc_pkg::digit_count(FRAC_BITS);
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_TUNE, ST_TUNE_DUTY, ST_KP, ST_INTEG, ST_DIV,
		ST_IMUL_INIT, ST_IMUL, ST_ICAP, ST_SUM, ST_RUN_DUTY, ST_FIN
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               accept;
	logic               out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_ERR;
				end
				ST_ERR:       state_q <= stat.tuned ? ST_KP : ST_TUNE;
				ST_TUNE:      state_q <= ST_TUNE_DUTY;
				ST_TUNE_DUTY: state_q <= ST_FIN;
				ST_KP:        state_q <= ST_INTEG;
				ST_INTEG: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IMUL_INIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IMUL_INIT: state_q <= ST_IMUL;
				ST_IMUL: begin
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_ICAP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ICAP:     state_q <= ST_SUM;
				ST_SUM:      state_q <= ST_RUN_DUTY;
				ST_RUN_DUTY: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.idx      = pahc_pkg::IDX_W'(cnt_q);
		cmd.capture  = accept;
		cmd.out_load = (state_q == ST_FIN) && out_free;
		case (state_q)
			ST_ERR:       cmd.op = pahc_pkg::OP_ERR;
			ST_TUNE:      cmd.op = pahc_pkg::OP_TUNE;
			ST_TUNE_DUTY: cmd.op = pahc_pkg::OP_TUNE_DUTY;
			ST_KP:        cmd.op = pahc_pkg::OP_KP;
			ST_INTEG:     cmd.op = pahc_pkg::OP_INTEG;
			ST_DIV:       cmd.op = pahc_pkg::OP_DIV_STEP;
			ST_IMUL_INIT: cmd.op = pahc_pkg::OP_IMUL_INIT;
			ST_IMUL:      cmd.op = pahc_pkg::OP_IMUL_STEP;
			ST_ICAP:      cmd.op = pahc_pkg::OP_ICAP;
			ST_SUM:       cmd.op = pahc_pkg::OP_SUM;
			ST_RUN_DUTY:  cmd.op = pahc_pkg::OP_RUN_DUTY;
			default:      cmd.op = pahc_pkg::OP_NONE;
		endcase
	end

	`PAHC_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> in_stall)
	`PAHC_ASSERT_IMP(a_digit_range, clk, arst_n, state_q == ST_IMUL, cnt_q < CNT_W'(MUL_STEPS))
	`PAHC_ASSERT_IMP(a_result_from_fin, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_FIN)

endmodule

>>> src/pahc_dpath.sv
// ----------------------------------------------------------------------------
// Autotuned heater controller datapath
// Configuration, tuning state, PI arithmetic, divider and result registers.
// ----------------------------------------------------------------------------
module pahc_dpath #(
	parameter int SAMPLE_BITS = pahc_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = pahc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pahc_pkg::dp_cmd_t                   cmd,
	output pahc_pkg::dp_stat_t                  stat,
	input  logic [pahc_pkg::TEMP_W-1:0]         temperature,
	input  logic                                cfg_we,
	input  logic [pahc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pahc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [pahc_pkg::DUTY_W-1:0]         duty,
	output logic                                tuned,
	output logic [pahc_pkg::GAIN_W-1:0]         ultimate_gain,
	output logic [pahc_pkg::TIME_W-1:0]         ultimate_period
);
`include "pid_autotune_heater_control_assert.svh"

	localparam int S      = SAMPLE_BITS;
	localparam int F      = FRAC_BITS;
	localparam int GW     = pahc_pkg::GAIN_W;
	localparam int TW     = pahc_pkg::TIME_W;
	localparam int DW     = pahc_pkg::DUTY_W;
	localparam int E_W    = S + 1;
	localparam int KP_W   = GW;
	localparam int KI_W   = pahc_pkg::ki_width(F);
	localparam int INT_W  = pahc_pkg::LIM_W + F + 1;
	localparam int MAG_W  = pahc_pkg::LIM_W + F;
	localparam int NDIG   = pahc_pkg::digit_count(F);
	localparam int MAGP_W = NDIG * pahc_pkg::DIGIT_W;
	localparam int EP_W   = E_W + pahc_pkg::TICK_W + 1;
	localparam int ADD_W  = (INT_W > EP_W ? INT_W : EP_W) + 1;
	localparam int PRAW_W = KI_W + MAGP_W;
	localparam int PROD_W = PRAW_W > 65 ? PRAW_W : 65;
	localparam int PT_W   = KP_W + 1 + E_W;
	localparam int TOT_W  = 63;
	localparam int TP_W   = GW + S;
	localparam longint SIX_L = ((longint'(6) << F) + 5) / 10;
	localparam logic [F-1:0] SIX = F'(SIX_L);
	localparam logic [GW+F:0] HALF = (GW+F+1)'(1) << (F - 1);

	// configuration
	logic [pahc_pkg::TEMP_W-1:0] target_q;
	logic [GW-1:0]               gain_start_q;
	logic [pahc_pkg::STEP_W-1:0] step_q;
	logic [pahc_pkg::TICK_W-1:0] tick_q;
	logic [pahc_pkg::LIM_W-1:0]  limit_q;
	logic [DW-1:0]               duty_lim_q;

	// tuning and loop state
	logic [S-1:0]     stored_q;
	logic [GW-1:0]    gain_q;
	logic [TW-1:0]    elapsed_q;
	logic [1:0]       count_q;
	logic [TW-1:0]    ct0_q, ct1_q;
	logic             complete_q;
	logic signed [INT_W-1:0] isum_q;

	// working registers
	logic [S-1:0]              sample_q;
	logic signed [E_W-1:0]     err_q;
	logic [TP_W-1:0]           tprod_q;
	logic [KP_W-1:0]           kp_q;
	logic signed [EP_W-1:0]    ep_q;
	logic [TW-1:0]             rem_q;
	logic [KI_W-1:0]           quo_q;
	logic [KI_W-1:0]           ki_q;
	logic [MAGP_W-1:0]         mag_q;
	logic [PROD_W-1:0]         acc_q;
	logic signed [PT_W-1:0]    pt_q;
	logic [pahc_pkg::ITERM_CAP_W-1:0] iprod_q;
	logic signed [TOT_W-1:0]   total_q;
	logic [DW-1:0]             dres_q;

	logic [DW-1:0] duty_q;
	logic          tuned_q;
	logic [GW-1:0] ku_q;
	logic [TW-1:0] tu_q;

	logic [S-1:0]            tgt;
	logic signed [E_W-1:0]   err_c;
	logic                    crossing;
	logic [1:0]              count_nx;
	logic [GW:0]             gain_sum;
	logic [TP_W-1:0]         tprod_c;
	logic [TP_W-F-1:0]       tq;
	logic [GW+F:0]           kp_full;
	logic signed [EP_W-1:0]  ep_c;
	logic signed [ADD_W-1:0] sum_add, lim_pos, lim_neg, sum_clamp;
	logic [TW:0]             rem_sh;
	logic                    ge;
	logic [TW-1:0]           tu_c;
	logic [INT_W-1:0]        abs_c;
	logic [pahc_pkg::DIGIT_W-1:0] digit;
	logic [KI_W+pahc_pkg::DIGIT_W-1:0] partial;
	logic [PROD_W-1:0]       sh_c;
	logic                    ovf;
	logic signed [PT_W-1:0]  pt_c;
	logic [TOT_W-1:0]        rq;

	assign tgt      = S'(target_q);
	assign err_c    = $signed({1'b0, tgt}) - $signed({1'b0, stored_q});
	assign crossing = (sample_q > tgt) && (stored_q < tgt);
	assign count_nx = count_q + {1'b0, crossing};
	assign gain_sum = {1'b0, gain_q} + (GW+1)'(step_q);
	assign tprod_c  = (!err_q[E_W-1] && err_q != '0) ? gain_q * err_q[S-1:0] : '0;
	assign tq       = tprod_q[TP_W-1:F];
	assign kp_full  = gain_q * SIX + HALF;
	assign ep_c     = err_q * $signed({1'b0, tick_q});
	assign sum_add  = ADD_W'(isum_q) + ADD_W'(ep_q);
	assign lim_pos  = ADD_W'({limit_q, {F{1'b0}}});
	assign lim_neg  = -lim_pos;
	assign rem_sh   = {rem_q, quo_q[KI_W-1]};
	assign ge       = rem_sh >= {1'b0, tu_c};
	assign tu_c     = ct1_q - ct0_q;
	assign abs_c    = isum_q[INT_W-1] ? -isum_q : isum_q;
	assign digit    = mag_q[cmd.idx*pahc_pkg::DIGIT_W +: pahc_pkg::DIGIT_W];
	assign partial  = ki_q * digit;
	assign sh_c     = acc_q >> F;
	assign ovf      = |acc_q[PROD_W-1:64];
	assign pt_c     = $signed({1'b0, kp_q}) * err_q;
	assign rq       = total_q >>> F;

	always_comb begin
		if (sum_add > lim_pos) sum_clamp = lim_pos;
		else if (sum_add < lim_neg) sum_clamp = lim_neg;
		else sum_clamp = sum_add;
	end

	// configuration writes; a gain_start write also restarts the tuning gain until tuning completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= pahc_pkg::TARGET_RST;
			gain_start_q <= pahc_pkg::GAIN_START_RST;
			step_q       <= pahc_pkg::GAIN_STEP_RST;
			tick_q       <= pahc_pkg::TICK_RST;
			limit_q      <= pahc_pkg::LIMIT_RST;
			duty_lim_q   <= pahc_pkg::DUTY_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pahc_pkg::REG_TARGET_TEMP:    target_q     <= cfg_data[pahc_pkg::TEMP_W-1:0];
				pahc_pkg::REG_GAIN_START:     gain_start_q <= cfg_data[GW-1:0];
				pahc_pkg::REG_GAIN_STEP:      step_q       <= cfg_data[pahc_pkg::STEP_W-1:0];
				pahc_pkg::REG_TICK_PERIOD:    tick_q       <= cfg_data[pahc_pkg::TICK_W-1:0];
				pahc_pkg::REG_INTEGRAL_LIMIT: limit_q      <= cfg_data[pahc_pkg::LIM_W-1:0];
				pahc_pkg::REG_DUTY_LIMIT:     duty_lim_q   <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q   <= '0;
			gain_q     <= pahc_pkg::GAIN_START_RST;
			elapsed_q  <= '0;
			count_q    <= '0;
			ct0_q      <= '0;
			ct1_q      <= '0;
			complete_q <= 1'b0;
			isum_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == pahc_pkg::REG_GAIN_START && !complete_q) begin
				gain_q <= cfg_data[GW-1:0];
			end
			case (cmd.op)
				pahc_pkg::OP_TUNE: begin
					if (crossing && count_q == 2'd0) ct0_q <= elapsed_q;
					if (crossing && count_q == 2'd1) ct1_q <= elapsed_q;
					stored_q  <= sample_q;
					elapsed_q <= elapsed_q + TW'(tick_q);
					if (count_nx >= 2'd2) begin
						count_q    <= 2'd2;
						complete_q <= 1'b1;
					end else begin
						count_q <= count_nx;
						gain_q  <= gain_sum[GW] ? {GW{1'b1}} : gain_sum[GW-1:0];
					end
				end
				pahc_pkg::OP_INTEG:    isum_q   <= INT_W'(sum_clamp);
				pahc_pkg::OP_RUN_DUTY: stored_q <= sample_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) sample_q <= S'(temperature);
		case (cmd.op)
			pahc_pkg::OP_ERR:  err_q   <= err_c;
			pahc_pkg::OP_TUNE: tprod_q <= tprod_c;
			pahc_pkg::OP_TUNE_DUTY: begin
				dres_q <= (tq > (TP_W-F)'(duty_lim_q)) ? duty_lim_q : tq[DW-1:0];
			end
			pahc_pkg::OP_KP: begin
				kp_q <= KP_W'(kp_full >> F);
				ep_q <= ep_c;
			end
			pahc_pkg::OP_INTEG: begin
				rem_q <= '0;
				quo_q <= {kp_q, {(F+1){1'b0}}};
			end
			pahc_pkg::OP_DIV_STEP: begin
				rem_q <= ge ? TW'(rem_sh - {1'b0, tu_c}) : TW'(rem_sh);
				quo_q <= {quo_q[KI_W-2:0], ge};
			end
			pahc_pkg::OP_IMUL_INIT: begin
				ki_q  <= (tu_c == '0) ? '0 : quo_q;
				mag_q <= MAGP_W'(abs_c[MAG_W-1:0]);
				acc_q <= '0;
				pt_q  <= pt_c;
			end
			pahc_pkg::OP_IMUL_STEP: begin
				acc_q <= acc_q + (PROD_W'(partial) << (cmd.idx * pahc_pkg::DIGIT_W));
			end
			pahc_pkg::OP_ICAP: begin
				iprod_q <= (ovf || sh_c > PROD_W'(pahc_pkg::ITERM_CAP)) ?
					pahc_pkg::ITERM_CAP : sh_c[pahc_pkg::ITERM_CAP_W-1:0];
			end
			pahc_pkg::OP_SUM: begin
				total_q <= isum_q[INT_W-1] ?
					TOT_W'(pt_q) - $signed({2'b00, iprod_q}) :
					TOT_W'(pt_q) + $signed({2'b00, iprod_q});
			end
			pahc_pkg::OP_RUN_DUTY: begin
				if (total_q <= 0) dres_q <= '0;
				else if (rq > TOT_W'(duty_lim_q)) dres_q <= duty_lim_q;
				else dres_q <= rq[DW-1:0];
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			duty_q  <= dres_q;
			tuned_q <= complete_q;
			ku_q    <= complete_q ? gain_q : '0;
			tu_q    <= complete_q ? tu_c : '0;
		end
	end

	assign stat.tuned      = complete_q;
	assign duty            = duty_q;
	assign tuned           = tuned_q;
	assign ultimate_gain   = ku_q;
	assign ultimate_period = tu_q;

	`PAHC_ASSERT_IMP(a_done_two_crossings, clk, arst_n, complete_q, count_q == 2'd2)
	`PAHC_ASSERT_IMP(a_gain_frozen, clk, arst_n, complete_q && $past(complete_q), $stable(gain_q))

endmodule

>>> src/pid_autotune_heater_control.sv
// ----------------------------------------------------------------------------
// Self-tuning heater controller, top level
// Ziegler-Nichols relay-free tuning by gain ramp, then clamped PI control.
// ----------------------------------------------------------------------------
// Each accepted request is one control tick carrying a fresh temperature
// sample and yields exactly one result (duty, tuned flag, Ku, Tu). The tick
// always acts on the sample kept from the previous tick. While tuning, the
// tick runs the error, tuning and duty steps before the result is registered;
// once tuned it runs the error, Kp and integral steps, the restoring divider
// that forms Ki = 2*Kp/Tu one quotient bit per cycle (KI_W = 41 bits), the
// I-term multiplier that consumes the integral magnitude one byte per cycle
// (DIGITS = 4), then the I-term cap, sum and duty steps. The last step holds
// for as long as the previous result still waits in the output register. One
// request is in work at a time; the next is taken in the cycle after the
// result is registered, even while that result waits for the sink.
// Configuration writes are always accepted (cfg_ready tied high) but belong
// in idle periods only.
// ----------------------------------------------------------------------------
module pid_autotune_heater_control #(
	parameter int SAMPLE_BITS = pahc_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = pahc_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample requests
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pahc_pkg::TEMP_W-1:0]     temperature,
	// results
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pahc_pkg::DUTY_W-1:0]     duty,
	output logic                            tuned,
	output logic [pahc_pkg::GAIN_W-1:0]     ultimate_gain,
	output logic [pahc_pkg::TIME_W-1:0]     ultimate_period,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pahc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pahc_pkg::CFG_DATA_W-1:0] cfg_data
);

	pahc_pkg::dp_cmd_t  cmd;
	pahc_pkg::dp_stat_t stat;

	// registers never back-pressure
	assign cfg_ready = 1'b1;

	// sequencer: steps the datapath and owns both handshakes
	pahc_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: hold configuration, tuning state and the PI arithmetic
	pahc_dpath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.temperature     (temperature),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.duty            (duty),
		.tuned           (tuned),
		.ultimate_gain   (ultimate_gain),
		.ultimate_period (ultimate_period)
	);

endmodule
